>>> rtl/tlb_pkg.sv
package tlb_pkg;

    // Default slot count; slot index and slot count widths
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int SLOT_W          = 6;
    localparam int COUNT_W         = 7;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_FILL   = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENTRIES = 2'd0;
    localparam logic [1:0] CFG_REPLACE = 2'd1;
    localparam logic [1:0] CFG_PAGE    = 2'd2;

    // Register reset values
    localparam logic [4:0]  ENTRIES_RST = 5'd16;
    localparam logic [16:0] PAGE_RST    = 17'd4096;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] process_id;
        logic [31:0] logical_address;
        logic [19:0] walked_frame;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] page_number;
        logic [19:0] frame;
        logic [35:0] physical_address;
        logic        evicted;
    } out_item_t;

    // One stored translation, without its use stamp
    typedef struct packed {
        logic [15:0] process;
        logic [31:0] page;
        logic [19:0] frame;
        logic [31:0] insert_stamp;
    } entry_t;

    // Sequencer requests to the entry store
    typedef struct packed {
        logic        flush;
        logic        trim;
        count_t      trim_count;
        logic        rd_en;
        slot_t       rd_idx;
        logic        ent_we;
        slot_t       ent_idx;
        entry_t      ent_wdata;
        logic        use_we;
        slot_t       use_idx;
        logic [31:0] use_wdata;
    } store_ctl_t;

endpackage

>>> rtl/tlb_alu.sv
// Shared subtractor: divide steps and entry age, borrow in the top bit
module tlb_alu
(
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [32:0] diff
);

    assign diff = {1'b0, a} - {1'b0, b};

endmodule

>>> rtl/tlb_store.sv
module tlb_store #(
    parameter int MAX_ENTRIES = tlb_pkg::MAX_ENTRIES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tlb_pkg::store_ctl_t    ctl,
    output tlb_pkg::entry_t        ent_rdata,
    output logic [31:0]            use_rdata,
    output logic [MAX_ENTRIES-1:0] valid
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    tlb_pkg::entry_t        ent_mem [MAX_ENTRIES];
    logic [31:0]            use_mem [MAX_ENTRIES];
    tlb_pkg::entry_t        ent_rdata_reg;
    logic [31:0]            use_rdata_reg;
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;

    // Entry and stamp memories, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.ent_we)
        begin
            ent_mem[ctl.ent_idx[IDX_W-1:0]] <= ctl.ent_wdata;
        end
        if (ctl.use_we)
        begin
            use_mem[ctl.use_idx[IDX_W-1:0]] <= ctl.use_wdata;
        end
        if (ctl.rd_en)
        begin
            ent_rdata_reg <= ent_mem[ctl.rd_idx[IDX_W-1:0]];
            use_rdata_reg <= use_mem[ctl.rd_idx[IDX_W-1:0]];
        end
    end

    // Valid bits: flush, trim above the usable count, set on fill
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (ctl.flush)
            begin
                valid_next[i] = 1'b0;
            end
            if (ctl.trim && (tlb_pkg::count_t'(i) >= ctl.trim_count))
            begin
                valid_next[i] = 1'b0;
            end
        end
        if (ctl.ent_we)
        begin
            valid_next[ctl.ent_idx[IDX_W-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ent_rdata = ent_rdata_reg;
    assign use_rdata = use_rdata_reg;
    assign valid     = valid_reg;

endmodule

>>> rtl/tlb_lookup_fill_fifo_lru.sv
// Channel   Direction  Handshake             Item
// in        input      in_valid / in_stall    tlb_pkg::in_item_t
// out       output     out_valid / out_stall  tlb_pkg::out_item_t
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Lookup and fill hold in_stall high through the divide, scan, update,
// multiply and result load states: 32 restoring divide steps and a scan of
// the n usable slots share one subtractor; the scan is skipped when n is zero.
// A lookup miss skips the multiply. Flush and the unused code go straight
// to the result load. The next item is taken while in_stall is low.
// Reset clears all valid bits at once; no clearing pass is needed.
// A result waits in the output register while out_stall is high; the next
// item is taken meanwhile and is held before its own result load.
module tlb_lookup_fill_fifo_lru #(
    parameter int MAX_ENTRIES = tlb_pkg::MAX_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  tlb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tlb_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    // Saturate an entry count to the slot count
    function automatic tlb_pkg::count_t clamp_count(input logic [4:0] value);
        if (32'(value) > 32'(MAX_ENTRIES))
        begin
            return tlb_pkg::count_t'(MAX_ENTRIES);
        end
        return tlb_pkg::count_t'(value);
    endfunction

    logic [2:0]          state_reg, state_next;
    tlb_pkg::in_item_t   item_reg, item_next;
    logic [4:0]          entries_reg, entries_next;
    logic                lru_reg, lru_next;
    logic [16:0]         page_reg, page_next;
    logic [31:0]         counter_reg, counter_next;
    logic [31:0]         quo_reg, quo_next;
    logic [16:0]         rem_reg, rem_next;
    logic [4:0]          bit_cnt_reg, bit_cnt_next;
    tlb_pkg::count_t     scan_cnt_reg, scan_cnt_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                rd_live_reg, rd_live_next;
    logic                found_match_reg, found_match_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [19:0]         match_frame_reg, match_frame_next;
    logic                found_free_reg, found_free_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [31:0]         best_age_reg, best_age_next;
    tlb_pkg::out_item_t  res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    tlb_pkg::out_item_t  out_data_reg, out_data_next;

    tlb_pkg::store_ctl_t ctl;
    tlb_pkg::entry_t     ent_rd;
    logic [31:0]         use_rd;
    logic [MAX_ENTRIES-1:0] valid_vec;

    tlb_pkg::count_t     usable;
    logic [16:0]         ps_eff;
    logic [17:0]         shifted;
    logic [31:0]         stamp;
    logic [31:0]         alu_a, alu_b;
    logic [32:0]         alu_diff;
    logic [31:0]         cnt_inc;
    logic [36:0]         mul_full;
    logic [IDX_W-1:0]    fill_slot;

    tlb_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ent_rdata (ent_rd),
        .use_rdata (use_rd),
        .valid     (valid_vec)
    );

    // Shared subtractor: divide step or entry age against the advanced counter
    assign usable  = clamp_count(entries_reg);
    assign ps_eff  = (page_reg == 17'd0) ? 17'd1 : page_reg;
    assign shifted = {rem_reg, quo_reg[31]};
    assign stamp   = lru_reg ? use_rd : ent_rd.insert_stamp;
    assign alu_a   = (state_reg == S_DIV) ? 32'(shifted) : cnt_inc;
    assign alu_b   = (state_reg == S_DIV) ? 32'(ps_eff) : stamp;

    tlb_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff)
    );

    assign cnt_inc   = counter_reg + 32'd1;
    assign mul_full  = 37'(res_reg.frame) * 37'(ps_eff);
    assign fill_slot = found_match_reg ? match_idx_reg :
                       (found_free_reg ? free_idx_reg : best_idx_reg);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        entries_next     = entries_reg;
        lru_next         = lru_reg;
        page_next        = page_reg;
        counter_next     = counter_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        bit_cnt_next     = bit_cnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        rd_idx_next      = rd_idx_reg;
        rd_live_next     = rd_live_reg;
        found_match_next = found_match_reg;
        match_idx_next   = match_idx_reg;
        match_frame_next = match_frame_reg;
        found_free_next  = found_free_reg;
        free_idx_next    = free_idx_reg;
        best_idx_next    = best_idx_reg;
        best_age_next    = best_age_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        ctl              = '0;

        // Configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tlb_pkg::CFG_ENTRIES:
                begin
                    entries_next   = cfg_data[4:0];
                    ctl.trim       = 1'b1;
                    ctl.trim_count = clamp_count(cfg_data[4:0]);
                end
                tlb_pkg::CFG_REPLACE:
                begin
                    lru_next = cfg_data[0];
                end
                tlb_pkg::CFG_PAGE:
                begin
                    page_next = cfg_data[16:0];
                end
                default:
                begin
                end
            endcase
        end

        // Result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_data;
                    unique case (in_data.operation)
                        tlb_pkg::OP_LOOKUP, tlb_pkg::OP_FILL:
                        begin
                            quo_next     = in_data.logical_address;
                            rem_next     = '0;
                            bit_cnt_next = '0;
                            state_next   = S_DIV;
                        end
                        tlb_pkg::OP_FLUSH:
                        begin
                            ctl.flush  = 1'b1;
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // One quotient bit per cycle
            S_DIV:
            begin
                if (!alu_diff[32])
                begin
                    rem_next = alu_diff[16:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[16:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd31)
                begin
                    scan_cnt_next    = '0;
                    rd_live_next     = 1'b0;
                    found_match_next = 1'b0;
                    found_free_next  = 1'b0;
                    best_idx_next    = '0;
                    best_age_next    = '0;
                    state_next       = (usable == '0) ? S_UPD : S_SCAN;
                end
            end

            // Read one slot per cycle, judge the slot read last cycle
            S_SCAN:
            begin
                if (rd_live_reg)
                begin
                    if (valid_vec[rd_idx_reg] && !found_match_reg &&
                        (ent_rd.process == item_reg.process_id) &&
                        (ent_rd.page == quo_reg))
                    begin
                        found_match_next = 1'b1;
                        match_idx_next   = rd_idx_reg;
                        match_frame_next = ent_rd.frame;
                    end
                    if (!valid_vec[rd_idx_reg] && !found_free_reg)
                    begin
                        found_free_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if ((rd_idx_reg == '0) || (alu_diff[31:0] > best_age_reg))
                    begin
                        best_idx_next = rd_idx_reg;
                        best_age_next = alu_diff[31:0];
                    end
                end
                if (scan_cnt_reg < usable)
                begin
                    ctl.rd_en     = 1'b1;
                    ctl.rd_idx    = tlb_pkg::slot_t'(scan_cnt_reg[IDX_W-1:0]);
                    rd_idx_next   = scan_cnt_reg[IDX_W-1:0];
                    rd_live_next  = 1'b1;
                    scan_cnt_next = scan_cnt_reg + tlb_pkg::count_t'(1);
                end
                else
                begin
                    rd_live_next = 1'b0;
                    state_next   = S_UPD;
                end
            end

            // Apply the hit or the fill
            S_UPD:
            begin
                res_next             = '0;
                res_next.page_number = quo_reg;
                if (item_reg.operation == tlb_pkg::OP_LOOKUP)
                begin
                    if (found_match_reg)
                    begin
                        counter_next   = cnt_inc;
                        ctl.use_we     = 1'b1;
                        ctl.use_idx    = tlb_pkg::slot_t'(match_idx_reg);
                        ctl.use_wdata  = cnt_inc;
                        res_next.hit   = 1'b1;
                        res_next.frame = match_frame_reg;
                        state_next     = S_MUL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    res_next.frame = item_reg.walked_frame;
                    if (usable != '0)
                    begin
                        counter_next                = cnt_inc;
                        ctl.ent_we                  = 1'b1;
                        ctl.ent_idx                 = tlb_pkg::slot_t'(fill_slot);
                        ctl.ent_wdata.process       = item_reg.process_id;
                        ctl.ent_wdata.page          = quo_reg;
                        ctl.ent_wdata.frame         = item_reg.walked_frame;
                        ctl.ent_wdata.insert_stamp  = cnt_inc;
                        ctl.use_we                  = 1'b1;
                        ctl.use_idx                 = tlb_pkg::slot_t'(fill_slot);
                        ctl.use_wdata               = cnt_inc;
                        res_next.evicted            = !found_match_reg && !found_free_reg;
                    end
                    state_next = S_MUL;
                end
            end

            // Frame times page size plus offset, wrapped to 36 bits
            S_MUL:
            begin
                res_next.physical_address = mul_full[35:0] + 36'(rem_reg);
                state_next                = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= tlb_pkg::ENTRIES_RST;
            lru_reg       <= 1'b0;
            page_reg      <= tlb_pkg::PAGE_RST;
            counter_reg   <= '0;
            rd_live_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            entries_reg   <= entries_next;
            lru_reg       <= lru_next;
            page_reg      <= page_next;
            counter_reg   <= counter_next;
            rd_live_reg   <= rd_live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        bit_cnt_reg     <= bit_cnt_next;
        scan_cnt_reg    <= scan_cnt_next;
        rd_idx_reg      <= rd_idx_next;
        found_match_reg <= found_match_next;
        match_idx_reg   <= match_idx_next;
        match_frame_reg <= match_frame_next;
        found_free_reg  <= found_free_next;
        free_idx_reg    <= free_idx_next;
        best_idx_reg    <= best_idx_next;
        best_age_reg    <= best_age_next;
        res_reg         <= res_next;
        out_data_reg    <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/tlb_chk.sv
module tlb_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input tlb_pkg::out_item_t out_data,
    input logic               cfg_ready
);

    // An accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an item was taken");

    // No configuration write while an item is in flight
    a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cfg_ready)
        else $error("configuration open while busy");

    // A hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.hit |-> !out_data.evicted)
        else $error("hit item marked evicted");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind tlb_lookup_fill_fifo_lru tlb_chk u_chk (.*);

>>> tb/sv/tlb_lookup_fill_fifo_lru_test.sv
`timescale 1ns / 1ps

module tlb_lookup_fill_fifo_lru_test;

    localparam int         SLOTS     = tlb_pkg::MAX_ENTRIES_DEF;
    localparam int         POOL_MAX  = 32;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Block ports
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    tlb_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tlb_pkg::out_item_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = tlb_pkg::CFG_ENTRIES;
    logic [31:0]        cfg_data  = '0;

    // Shadow copy of the configuration and the entry store
    logic [4:0]  m_entries   = tlb_pkg::ENTRIES_RST;
    logic        m_lru       = 1'b0;
    logic [16:0] m_page_size = tlb_pkg::PAGE_RST;
    logic        m_valid     [SLOTS] = '{default: 1'b0};
    logic [15:0] m_pid       [SLOTS] = '{default: '0};
    logic [31:0] m_vpage     [SLOTS] = '{default: '0};
    logic [19:0] m_frame     [SLOTS] = '{default: '0};
    logic [31:0] m_inserted  [SLOTS] = '{default: '0};
    logic [31:0] m_used      [SLOTS] = '{default: '0};
    logic [31:0] m_clock     = '0;

    // Translations expected back from the block, oldest first
    tlb_pkg::out_item_t pending_xlat[$];

    // Working set of (process, page) pairs for the random items
    logic [15:0] pool_pid  [POOL_MAX];
    logic [31:0] pool_page [POOL_MAX];
    int          pool_n = 1;

    // Idling control
    logic        calm     = 1'b0;
    logic        hold_go  = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    // Run bookkeeping
    int mismatches    = 0;
    int results_seen  = 0;
    int n_lookups     = 0;
    int n_hits        = 0;
    int n_fills       = 0;
    int n_evictions   = 0;
    int n_flushes     = 0;
    int n_unused      = 0;
    int n_settings    = 0;

    tlb_lookup_fill_fifo_lru DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #5_000_000;
        $display("Timeout waiting for the block");
        $display("Mismatches found");
        $finish;
    end

    // Expected translation for one accepted item; updates the shadow store
    function automatic tlb_pkg::out_item_t translate(tlb_pkg::in_item_t req);
        tlb_pkg::out_item_t res;
        logic [63:0] ps;
        logic [63:0] addr;
        logic [63:0] offset;
        logic [31:0] vpage;
        logic [31:0] stamp;
        logic [31:0] age;
        logic [31:0] best_age;
        int          usable;
        int          slot;
        int          best;
        int          i;
        res      = '0;
        ps       = (m_page_size == 0) ? 64'd1 : 64'(m_page_size);
        addr     = 64'(req.logical_address);
        vpage    = 32'(addr / ps);
        offset   = addr % ps;
        usable   = (m_entries > SLOTS) ? SLOTS : int'(m_entries);
        slot     = -1;
        best     = 0;
        best_age = '0;
        for (i = usable - 1; i >= 0; i--)
            if (m_valid[i] && m_pid[i] == req.process_id && m_vpage[i] == vpage)
                slot = i;
        res.page_number = vpage;
        case (req.operation)
            tlb_pkg::OP_LOOKUP:
            begin
                n_lookups++;
                if (slot >= 0)
                begin
                    n_hits++;
                    m_clock++;
                    m_used[slot]         = m_clock;
                    res.hit              = 1'b1;
                    res.frame            = m_frame[slot];
                    res.physical_address = 36'(64'(m_frame[slot]) * ps + offset);
                end
            end
            tlb_pkg::OP_FILL:
            begin
                n_fills++;
                res.frame            = req.walked_frame;
                res.physical_address = 36'(64'(req.walked_frame) * ps + offset);
                if (usable != 0)
                begin
                    m_clock++;
                    // not present: lowest free slot, else the oldest by policy
                    if (slot < 0)
                    begin
                        for (i = usable - 1; i >= 0; i--)
                            if (!m_valid[i])
                                slot = i;
                        if (slot < 0)
                        begin
                            for (i = 0; i < usable; i++)
                            begin
                                stamp = m_lru ? m_used[i] : m_inserted[i];
                                age   = m_clock - stamp;
                                if (i == 0 || age > best_age)
                                begin
                                    best_age = age;
                                    best     = i;
                                end
                            end
                            slot        = best;
                            res.evicted = 1'b1;
                            n_evictions++;
                        end
                    end
                    m_valid[slot]    = 1'b1;
                    m_pid[slot]      = req.process_id;
                    m_vpage[slot]    = vpage;
                    m_frame[slot]    = req.walked_frame;
                    m_inserted[slot] = m_clock;
                    m_used[slot]     = m_clock;
                end
            end
            tlb_pkg::OP_FLUSH:
            begin
                n_flushes++;
                for (i = 0; i < SLOTS; i++)
                    m_valid[i] = 1'b0;
                res.page_number = '0;
            end
            default:
            begin
                n_unused++;
                res.page_number = '0;
            end
        endcase
        return res;
    endfunction

    function automatic tlb_pkg::in_item_t make_req(logic [1:0] op, logic [15:0] pid,
                                                   logic [31:0] addr, logic [19:0] walked);
        tlb_pkg::in_item_t req;
        req.operation       = op;
        req.process_id      = pid;
        req.logical_address = addr;
        req.walked_frame    = walked;
        return req;
    endfunction

    // Pick a fresh working set that fits the current page size
    task automatic fresh_pool(int size);
        logic [63:0] ps;
        logic [63:0] pages;
        int          k;
        ps     = (m_page_size == 0) ? 64'd1 : 64'(m_page_size);
        pages  = 64'h1_0000_0000 / ps;
        pool_n = size;
        for (k = 0; k < size; k++)
        begin
            pool_pid[k]  = (k % 2 == 0) ? 16'($urandom_range(3)) : 16'($urandom);
            pool_page[k] = (k % 3 == 0) ? 32'($urandom_range(7))
                                        : 32'(64'($urandom) % pages);
        end
    endtask

    // Mostly lookups and fills over the working set, some raw noise
    function automatic tlb_pkg::in_item_t random_req();
        tlb_pkg::in_item_t req;
        logic [63:0] ps;
        int          roll;
        int          k;
        ps   = (m_page_size == 0) ? 64'd1 : 64'(m_page_size);
        req  = make_req(2'($urandom), 16'($urandom), $urandom, 20'($urandom));
        roll = $urandom_range(99);
        if (roll >= 20)
        begin
            k                   = $urandom_range(pool_n - 1);
            req.process_id      = pool_pid[k];
            req.logical_address = 32'(64'(pool_page[k]) * ps + 64'($urandom) % ps);
            req.operation       = (roll < 22) ? tlb_pkg::OP_FLUSH :
                                  (roll < 60) ? tlb_pkg::OP_FILL : tlb_pkg::OP_LOOKUP;
        end
        return req;
    endfunction

    // Offer one item, record its translation once accepted
    task automatic send_req(tlb_pkg::in_item_t req);
        if (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_xlat.push_back(translate(req));
    endtask

    // Stop offering and wait for every outstanding translation
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_xlat.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; only issued while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        int i;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            tlb_pkg::CFG_ENTRIES:
            begin
                m_entries = value[4:0];
                for (i = 0; i < SLOTS; i++)
                    if (i >= m_entries)
                        m_valid[i] = 1'b0;
            end
            tlb_pkg::CFG_REPLACE: m_lru       = value[0];
            tlb_pkg::CFG_PAGE:    m_page_size = value[16:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR result %0d %s: expected %0h, got %0h",
                         results_seen, fname, want, got);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_go != hold_seen)
        begin
            hold_seen = hold_go;
            hold_left = 400;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !calm && ($urandom_range(99) < 11);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        tlb_pkg::out_item_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_xlat.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR unexpected result %0h", out_data);
            end
            else
            begin
                want = pending_xlat.pop_front();
                check_field("hit", 64'(want.hit), 64'(out_data.hit));
                check_field("page_number", 64'(want.page_number),
                            64'(out_data.page_number));
                check_field("frame", 64'(want.frame), 64'(out_data.frame));
                check_field("physical_address", 64'(want.physical_address),
                            64'(out_data.physical_address));
                check_field("evicted", 64'(want.evicted), 64'(out_data.evicted));
            end
            results_seen++;
        end
    end

    // Hits, misses, in-place update, other process, unused code, flush
    task automatic test_basic_ops();
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'h0000, 32'h0000_0000, 20'h00000));
        send_req(make_req(tlb_pkg::OP_FILL,   16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'hFFFF, 32'hFFFF_F000, 20'h00000));
        send_req(make_req(tlb_pkg::OP_FILL,   16'hFFFF, 32'hFFFF_F123, 20'h12345));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'hFFFE, 32'hFFFF_FFFF, 20'h00000));
        send_req(make_req(OP_UNUSED,          16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF));
        send_req(make_req(tlb_pkg::OP_FLUSH,  16'hFFFF, 32'hFFFF_FFFF, 20'hFFFFF));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 20'h00000));
        drain();
    endtask

    // Two slots: touching the first entry decides the victim under LRU
    task automatic test_replacement(logic use_lru);
        write_reg(tlb_pkg::CFG_ENTRIES, 32'd2);
        write_reg(tlb_pkg::CFG_REPLACE, {31'd0, use_lru});
        send_req(make_req(tlb_pkg::OP_FILL,   16'h0001, 32'h0000_1000, 20'h000A1));
        send_req(make_req(tlb_pkg::OP_FILL,   16'h0001, 32'h0000_2000, 20'h000B2));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'h0001, 32'h0000_1004, 20'h00000));
        send_req(make_req(tlb_pkg::OP_FILL,   16'h0001, 32'h0000_3000, 20'h000C3));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'h0001, 32'h0000_2008, 20'h00000));
        drain();
    endtask

    // Disabled store, shrinking the slot count, oversized count
    task automatic test_entry_limits();
        write_reg(tlb_pkg::CFG_ENTRIES, 32'd0);
        send_req(make_req(tlb_pkg::OP_FILL,   16'h0002, 32'h0000_5000, 20'h00055));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'h0002, 32'h0000_5000, 20'h00000));
        drain();
        write_reg(tlb_pkg::CFG_ENTRIES, 32'd4);
        send_req(make_req(tlb_pkg::OP_FILL, 16'h0003, 32'h0000_1000, 20'h00011));
        send_req(make_req(tlb_pkg::OP_FILL, 16'h0003, 32'h0000_2000, 20'h00022));
        send_req(make_req(tlb_pkg::OP_FILL, 16'h0003, 32'h0000_3000, 20'h00033));
        drain();
        write_reg(tlb_pkg::CFG_ENTRIES, 32'd1);
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'h0003, 32'h0000_2000, 20'h00000));
        send_req(make_req(tlb_pkg::OP_LOOKUP, 16'h0003, 32'h0000_1FFF, 20'h00000));
        drain();
        // upper data bits are ignored; 31 saturates to the full store
        write_reg(tlb_pkg::CFG_ENTRIES, 32'hFFFF_FFFF);
    endtask

    // One setting, then a stream of random items over a fresh working set
    task automatic test_random_phase(logic [31:0] entries, logic [31:0] lru,
                                     logic [31:0] psize, int pool_size, int count,
                                     logic steady);
        drain();
        write_reg(tlb_pkg::CFG_ENTRIES, entries);
        write_reg(tlb_pkg::CFG_REPLACE, lru);
        write_reg(tlb_pkg::CFG_PAGE, psize);
        n_settings++;
        fresh_pool(pool_size);
        calm <= steady;
        repeat (count)
            send_req(random_req());
        drain();
        calm <= 1'b0;
    endtask

    // Receiver holds off while items keep coming; the input must back up
    task automatic test_backpressure();
        drain();
        write_reg(tlb_pkg::CFG_ENTRIES, 32'd16);
        write_reg(tlb_pkg::CFG_PAGE, 32'd4096);
        n_settings++;
        fresh_pool(10);
        hold_go <= !hold_go;
        repeat (40)
            send_req(random_req());
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_replacement(1'b0);
        test_replacement(1'b1);
        test_entry_limits();

        test_random_phase(32'd16, 32'd0, 32'd4096,   24, 80, 1'b0);
        test_random_phase(32'd16, 32'd1, 32'd4096,   24, 80, 1'b1);
        test_random_phase(32'd5,  32'd1, 32'd1,       8, 70, 1'b0);
        test_random_phase(32'd31, 32'd0, 32'd0,      20, 70, 1'b0);
        test_random_phase(32'd8,  32'd1, 32'd65536,  12, 70, 1'b0);
        test_random_phase(32'd16, 32'd0, 32'd131071, 30, 70, 1'b0);
        test_random_phase(32'd1,  32'd1, 32'($urandom_range(1, 131071)), 3, 60, 1'b0);
        test_random_phase(32'd3,  32'd0, 32'($urandom_range(1, 131071)), 6, 60, 1'b0);
        test_random_phase(32'($urandom_range(0, 31)), 32'($urandom_range(1)),
                          32'($urandom_range(0, 131071)), $urandom_range(2, 32), 70, 1'b0);
        test_backpressure();

        drain();
        repeat (60) @(posedge clk);
        mismatches += pending_xlat.size();

        $display("Checked %0d results over %0d random settings and the directed cases",
                 results_seen, n_settings);
        $display("%0d lookups (%0d hits), %0d fills (%0d evictions), %0d flushes, %0d unused",
                 n_lookups, n_hits, n_fills, n_evictions, n_flushes, n_unused);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
